@@ design/spd_pkg.sv @@
// Shared types, codes and CRC constants for the servo packet deframer.
`default_nettype none

package spd_pkg;

  localparam int unsigned MAX_LENGTH = 1024;
  localparam logic [15:0] CRC_POLY = 16'h8005;

  typedef enum logic [1:0] {
    REG_HEADER_FIRST    = 2'd0,
    REG_HEADER_SECOND   = 2'd1,
    REG_HEADER_THIRD    = 2'd2,
    REG_HEADER_RESERVED = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    STATUS_OK           = 3'd0,
    STATUS_CRC_MISMATCH = 3'd1,
    STATUS_INCOMPLETE   = 3'd2,
    STATUS_NO_HEADER    = 3'd3,
    STATUS_BAD_LENGTH   = 3'd4
  } status_t;

  typedef enum logic [5:0] {
    PH_SEARCH = 6'b000001,
    PH_ID     = 6'b000010,
    PH_LEN_LO = 6'b000100,
    PH_LEN_HI = 6'b001000,
    PH_BODY   = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  localparam logic RESULT_PARAM  = 1'b0;
  localparam logic RESULT_REPORT = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  param_byte;
    logic [15:0] header_offset;
    logic [7:0]  device_id;
    logic [7:0]  instruction;
    logic [7:0]  error_byte;
    logic [15:0] param_count;
    status_t     status;
  } out_item_t;

  // CRC contribution of each single bit of a 32-bit message, init zero
  function automatic logic [31:0][15:0] crc_columns();
    logic [31:0][15:0] cols;
    logic [15:0]       c;
    logic              fb;
    for (int i = 0; i < 32; i++) begin
      c = '0;
      for (int k = 31; k >= 0; k--) begin
        fb = c[15] ^ (k == i);
        c  = fb ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      cols[i] = c;
    end
    return cols;
  endfunction

  localparam logic [31:0][15:0] CRC_COLS = crc_columns();

  // parallel CRC of the four header bytes, XOR of independent columns
  function automatic logic [15:0] header_crc(input logic [31:0] word);
    logic [15:0] c;
    c = '0;
    for (int i = 0; i < 32; i++) begin
      if (word[i]) begin
        c = c ^ CRC_COLS[i];
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/servo_packet_deframer_unit.sv @@
// Servo packet deframer: header search, field capture, unstuffing and CRC check.
// An accepted byte beat's result is registered in the output register.
// Throughput: one byte beat per cycle; ready drops only while a held result is not taken.
// Each byte's phase step and CRC-16 update complete in the single stage before the
// output register. Synchronous active-high reset returns to header search with an
// empty output register and the header registers at FF FF FD 00.
`default_nettype none

module servo_packet_deframer_unit
  import spd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire cfg_reg_t  cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic [7:0]  header_first, header_second, header_third, header_reserved;

  phase_t      phase, phase_next;
  logic [23:0] recent_bytes, recent_bytes_next;
  logic [23:0] stuff_window, stuff_window_next;
  logic [15:0] buffer_position, buffer_position_next;
  logic [15:0] header_start, header_start_next;
  logic [15:0] length_value, length_value_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  captured_id, captured_id_next;
  logic [7:0]  captured_instruction, captured_instruction_next;
  logic [7:0]  captured_error, captured_error_next;
  logic [15:0] unstuffed_count, unstuffed_count_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;

  logic        in_accept;
  logic [23:0] trigger;
  logic [7:0]  byte_in;
  logic        eob;
  logic [15:0] body_index;
  logic [15:0] new_length;
  logic        do_report;
  logic        emit_param;
  status_t     report_status;
  out_item_t   result;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  assign in_ready   = !out_valid || out_ready;
  assign in_accept  = in_valid && in_ready;
  assign cfg_ready  = 1'b1;
  assign trigger    = {header_first, header_second, header_third};
  assign byte_in    = in_data.data_byte;
  assign eob        = in_data.end_of_buffer;
  assign body_index = length_value - bytes_remaining;
  assign new_length = {byte_in, length_value[7:0]};

  always_comb begin
    phase_next                = phase;
    recent_bytes_next         = recent_bytes;
    stuff_window_next         = stuff_window;
    buffer_position_next      = buffer_position;
    header_start_next         = header_start;
    length_value_next         = length_value;
    bytes_remaining_next      = bytes_remaining;
    running_crc_next          = running_crc;
    captured_id_next          = captured_id;
    captured_instruction_next = captured_instruction;
    captured_error_next       = captured_error;
    unstuffed_count_next      = unstuffed_count;
    crc_low_byte_next         = crc_low_byte;
    do_report                 = 1'b0;
    emit_param                = 1'b0;
    report_status             = STATUS_OK;
    result                    = '0;

    if (in_accept) begin
      case (phase)
        PH_SEARCH: begin
          if (buffer_position >= 16'd3 && recent_bytes == trigger &&
              byte_in == header_reserved) begin
            header_start_next         = buffer_position - 16'd3;
            running_crc_next          = header_crc({trigger, byte_in});
            captured_id_next          = '0;
            captured_instruction_next = '0;
            captured_error_next       = '0;
            unstuffed_count_next      = '0;
            stuff_window_next         = '0;
            phase_next                = PH_ID;
          end
          recent_bytes_next = {recent_bytes[15:0], byte_in};
        end
        PH_ID: begin
          captured_id_next = byte_in;
          running_crc_next = crc_byte(running_crc, byte_in);
          phase_next       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          length_value_next = {8'h00, byte_in};
          running_crc_next  = crc_byte(running_crc, byte_in);
          phase_next        = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          length_value_next = new_length;
          running_crc_next  = crc_byte(running_crc, byte_in);
          if (new_length < 16'd4 || new_length > 16'(MAX_LENGTH)) begin
            do_report     = 1'b1;
            report_status = STATUS_BAD_LENGTH;
            phase_next    = PH_DONE;
          end else begin
            bytes_remaining_next = new_length;
            phase_next           = PH_BODY;
          end
        end
        PH_BODY: begin
          if (bytes_remaining >= 16'd3) begin
            running_crc_next = crc_byte(running_crc, byte_in);
            if (body_index == 16'd0) begin
              captured_instruction_next = byte_in;
            end else if (body_index == 16'd1) begin
              captured_error_next = byte_in;
            end else begin
              stuff_window_next = {stuff_window[15:0], byte_in};
              // stuffed byte after a header-like triple is dropped
              if (!(body_index >= 16'd5 && stuff_window == trigger) && !eob) begin
                emit_param           = 1'b1;
                unstuffed_count_next = unstuffed_count + 16'd1;
              end
            end
          end else if (bytes_remaining == 16'd2) begin
            crc_low_byte_next = byte_in;
          end else begin
            do_report     = 1'b1;
            report_status = ({byte_in, crc_low_byte} == running_crc) ?
                            STATUS_OK : STATUS_CRC_MISMATCH;
            phase_next    = PH_DONE;
          end
          if (bytes_remaining != 16'd0) begin
            bytes_remaining_next = bytes_remaining - 16'd1;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase

      if (buffer_position != 16'hFFFF) begin
        buffer_position_next = buffer_position + 16'd1;
      end

      if (eob) begin
        if (!do_report && phase != PH_DONE) begin
          do_report     = 1'b1;
          report_status = (phase_next == PH_SEARCH) ? STATUS_NO_HEADER : STATUS_INCOMPLETE;
        end
        phase_next           = PH_SEARCH;
        buffer_position_next = '0;
        recent_bytes_next    = '0;
      end
    end

    if (do_report) begin
      result.result_kind = RESULT_REPORT;
      result.status      = report_status;
      if (report_status != STATUS_NO_HEADER) begin
        result.header_offset = header_start_next;
        result.device_id     = captured_id_next;
        result.instruction   = captured_instruction_next;
        result.error_byte    = captured_error_next;
        result.param_count   = unstuffed_count_next;
      end
    end else if (emit_param) begin
      result.result_kind = RESULT_PARAM;
      result.param_byte  = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SEARCH;
      recent_bytes    <= '0;
      buffer_position <= '0;
      out_valid       <= 1'b0;
    end else begin
      phase           <= phase_next;
      recent_bytes    <= recent_bytes_next;
      buffer_position <= buffer_position_next;
      if (in_accept) begin
        out_valid <= do_report || emit_param;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    stuff_window         <= stuff_window_next;
    header_start         <= header_start_next;
    length_value         <= length_value_next;
    bytes_remaining      <= bytes_remaining_next;
    running_crc          <= running_crc_next;
    captured_id          <= captured_id_next;
    captured_instruction <= captured_instruction_next;
    captured_error       <= captured_error_next;
    unstuffed_count      <= unstuffed_count_next;
    crc_low_byte         <= crc_low_byte_next;
    if (in_accept && (do_report || emit_param)) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first    <= 8'hFF;
      header_second   <= 8'hFF;
      header_third    <= 8'hFD;
      header_reserved <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEADER_FIRST:    header_first    <= cfg_data;
        REG_HEADER_SECOND:   header_second   <= cfg_data;
        REG_HEADER_THIRD:    header_third    <= cfg_data;
        REG_HEADER_RESERVED: header_reserved <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ tb/servo_packet_deframer_unit_tb.sv @@
// Self-checking testbench for the servo packet deframer: directed table, random buffers.
`default_nettype none

module servo_packet_deframer_unit_tb;
  import spd_pkg::*;

  typedef struct packed {
    logic       cfg_row;
    cfg_reg_t   reg_idx;
    logic [7:0] value;
    logic       eob;
    logic       pinned;
    out_item_t  want;
  } plan_row_t;

  localparam out_item_t NONE = '0;
  localparam out_item_t WANT_NO_HEADER =
    '{RESULT_REPORT, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, STATUS_NO_HEADER};
  localparam out_item_t WANT_CUT_AT_HEADER =
    '{RESULT_REPORT, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000, STATUS_INCOMPLETE};
  localparam out_item_t WANT_BAD_LENGTH =
    '{RESULT_REPORT, 8'h00, 16'h0000, 8'h01, 8'h00, 8'h00, 16'h0000, STATUS_BAD_LENGTH};

  localparam plan_row_t PLAN [28] = '{
    '{1'b0, REG_HEADER_FIRST, 8'h00, 1'b1, 1'b1, WANT_NO_HEADER},
    '{1'b0, REG_HEADER_FIRST, 8'hFF, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'hFF, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'hFD, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'h00, 1'b1, 1'b1, WANT_CUT_AT_HEADER},
    '{1'b0, REG_HEADER_FIRST, 8'hFF, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'hFF, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'hFD, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'h00, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'h01, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'h02, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'h00, 1'b1, 1'b1, WANT_BAD_LENGTH},
    '{1'b0, REG_HEADER_FIRST, 8'hFF, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'hFF, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'hFD, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'h00, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'hFE, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'h08, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'h00, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'h55, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'h80, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'hFF, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'hFF, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'hFD, 1'b0, 1'b0, NONE},
    '{1'b1, REG_HEADER_THIRD, 8'hFE, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'hFD, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'h00, 1'b0, 1'b0, NONE},
    '{1'b0, REG_HEADER_FIRST, 8'h00, 1'b1, 1'b0, NONE}
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_reg_t  cfg_index = REG_HEADER_FIRST;
  logic [7:0] cfg_data = 8'h00;

  // deframer state as predicted
  logic [7:0]  hdr [4] = '{8'hFF, 8'hFF, 8'hFD, 8'h00};
  phase_t      stage = PH_SEARCH;
  logic [23:0] last3 = '0;
  logic [23:0] param_tail = '0;
  logic [15:0] byte_pos = '0;
  logic [15:0] frame_at = '0;
  logic [15:0] frame_len = '0;
  logic [15:0] left = '0;
  logic [15:0] crc_acc = '0;
  logic [7:0]  got_id = '0;
  logic [7:0]  got_instr = '0;
  logic [7:0]  got_err = '0;
  logic [15:0] kept_params = '0;
  logic [7:0]  crc_first = '0;

  out_item_t   due_results [$];
  bit          pinned_now = 1'b0;
  out_item_t   pinned_want = '0;
  bit          calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned reports_seen = 0;
  int unsigned settings_used = 0;
  int unsigned fail_count = 0;

  servo_packet_deframer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      x = x[15] ? ({x[14:0], 1'b0} ^ CRC_POLY) : {x[14:0], 1'b0};
    end
    return x;
  endfunction

  function automatic out_item_t report_of(input status_t s);
    out_item_t r;
    r = '0;
    r.result_kind = RESULT_REPORT;
    r.status = s;
    if (s != STATUS_NO_HEADER) begin
      r.header_offset = frame_at;
      r.device_id = got_id;
      r.instruction = got_instr;
      r.error_byte = got_err;
      r.param_count = kept_params;
    end
    return r;
  endfunction

  function automatic bit deframe_byte(input in_item_t b, output out_item_t r);
    logic [15:0] pos;
    logic [15:0] idx;
    logic [23:0] trig;
    bit          hit;
    bit          done;
    bit          drop;
    pos = byte_pos;
    trig = {hdr[REG_HEADER_FIRST], hdr[REG_HEADER_SECOND], hdr[REG_HEADER_THIRD]};
    hit = 1'b0;
    done = 1'b0;
    r = '0;
    case (stage)
      PH_SEARCH: begin
        if (pos >= 16'd3 && last3 == trig && b.data_byte == hdr[REG_HEADER_RESERVED]) begin
          frame_at = pos - 16'd3;
          crc_acc = crc16_step(crc16_step(crc16_step(crc16_step(16'h0000,
                    hdr[REG_HEADER_FIRST]), hdr[REG_HEADER_SECOND]),
                    hdr[REG_HEADER_THIRD]), hdr[REG_HEADER_RESERVED]);
          got_id = '0;
          got_instr = '0;
          got_err = '0;
          kept_params = '0;
          param_tail = '0;
          frame_len = '0;
          left = '0;
          crc_first = '0;
          stage = PH_ID;
        end
        last3 = {last3[15:0], b.data_byte};
      end
      PH_ID: begin
        got_id = b.data_byte;
        crc_acc = crc16_step(crc_acc, b.data_byte);
        stage = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_len = {8'h00, b.data_byte};
        crc_acc = crc16_step(crc_acc, b.data_byte);
        stage = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frame_len = {b.data_byte, frame_len[7:0]};
        crc_acc = crc16_step(crc_acc, b.data_byte);
        if (frame_len < 16'd4 || frame_len > MAX_LENGTH) begin
          r = report_of(STATUS_BAD_LENGTH);
          hit = 1'b1;
          done = 1'b1;
          stage = PH_DONE;
        end else begin
          left = frame_len;
          stage = PH_BODY;
        end
      end
      PH_BODY: begin
        idx = frame_len - left;
        if (left >= 16'd3) begin
          crc_acc = crc16_step(crc_acc, b.data_byte);
          if (idx == 16'd0) begin
            got_instr = b.data_byte;
          end else if (idx == 16'd1) begin
            got_err = b.data_byte;
          end else begin
            // stuffing byte follows three raw bytes equal to the trigger
            drop = idx >= 16'd5 && param_tail == trig;
            param_tail = {param_tail[15:0], b.data_byte};
            if (!drop && !b.end_of_buffer) begin
              r.result_kind = RESULT_PARAM;
              r.param_byte = b.data_byte;
              hit = 1'b1;
              kept_params = kept_params + 16'd1;
            end
          end
        end else if (left == 16'd2) begin
          crc_first = b.data_byte;
        end else begin
          r = report_of(({b.data_byte, crc_first} == crc_acc) ? STATUS_OK
                                                            : STATUS_CRC_MISMATCH);
          hit = 1'b1;
          done = 1'b1;
          stage = PH_DONE;
        end
        if (left != 16'd0) begin
          left = left - 16'd1;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
    if (pos != 16'hFFFF) begin
      byte_pos = pos + 16'd1;
    end
    if (b.end_of_buffer) begin
      if (!done) begin
        r = report_of(stage == PH_SEARCH ? STATUS_NO_HEADER : STATUS_INCOMPLETE);
        hit = 1'b1;
      end
      stage = PH_SEARCH;
      byte_pos = '0;
      last3 = '0;
    end
    return hit;
  endfunction

  function automatic int unsigned pause_len();
    int unsigned r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end
    if (r < 94) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 9) < 4) begin
      return hdr[$urandom_range(0, 3)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t  %s mismatch: expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_beat(input in_item_t b, input bit pin, input out_item_t want);
    int unsigned gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_data = b;
    pinned_now = pin;
    pinned_want = want;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    gap = pause_len();
    if (gap != 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] v);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    hdr[idx] = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_headers(input logic [7:0] h0, input logic [7:0] h1,
                             input logic [7:0] h2, input logic [7:0] h3);
    write_reg(REG_HEADER_FIRST, h0);
    write_reg(REG_HEADER_SECOND, h1);
    write_reg(REG_HEADER_THIRD, h2);
    write_reg(REG_HEADER_RESERVED, h3);
    settings_used++;
  endtask

  task automatic append_packet(ref logic [7:0] pkt [$], input logic [15:0] len,
                               input bit spoil_crc);
    int unsigned first;
    int unsigned n;
    logic [15:0] c;
    first = pkt.size();
    pkt.push_back(hdr[REG_HEADER_FIRST]);
    pkt.push_back(hdr[REG_HEADER_SECOND]);
    pkt.push_back(hdr[REG_HEADER_THIRD]);
    pkt.push_back(hdr[REG_HEADER_RESERVED]);
    pkt.push_back(8'($urandom_range(0, 255)));
    pkt.push_back(len[7:0]);
    pkt.push_back(len[15:8]);
    if (len < 16'd4 || len > MAX_LENGTH) begin
      return;
    end
    pkt.push_back(pick_byte());
    pkt.push_back(pick_byte());
    n = 0;
    while (n < len - 4) begin
      if ($urandom_range(0, 9) < 2 && n + 4 <= len - 4) begin
        pkt.push_back(hdr[REG_HEADER_FIRST]);
        pkt.push_back(hdr[REG_HEADER_SECOND]);
        pkt.push_back(hdr[REG_HEADER_THIRD]);
        pkt.push_back(hdr[REG_HEADER_THIRD]);
        n += 4;
      end else begin
        pkt.push_back(pick_byte());
        n++;
      end
    end
    c = '0;
    for (int i = first; i < pkt.size(); i++) begin
      c = crc16_step(c, pkt[i]);
    end
    if (spoil_crc) begin
      c = c ^ 16'($urandom_range(1, 65535));
    end
    pkt.push_back(c[7:0]);
    pkt.push_back(c[15:8]);
  endtask

  task automatic send_buffer(ref logic [7:0] pkt [$], input int unsigned cut);
    for (int i = 0; i < cut; i++) begin
      send_beat('{data_byte: pkt[i], end_of_buffer: (i == cut - 1)}, 1'b0, NONE);
    end
  endtask

  task automatic random_buffer();
    logic [7:0]  pkt [$];
    logic [15:0] len;
    int unsigned kind;
    int unsigned r;
    int unsigned cut;
    kind = $urandom_range(0, 99);
    calm = ($urandom_range(0, 99) < 15);
    repeat ($urandom_range(0, 3)) pkt.push_back(pick_byte());
    if (kind < 8) begin
      repeat ($urandom_range(1, 12)) pkt.push_back(pick_byte());
    end else if (kind < 16) begin
      len = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 3))
                                         : 16'($urandom_range(MAX_LENGTH + 1, 65535));
      append_packet(pkt, len, 1'b0);
    end else begin
      len = ($urandom_range(0, 9) < 9) ? 16'($urandom_range(4, 24))
                                        : 16'($urandom_range(25, 200));
      append_packet(pkt, len, $urandom_range(0, 99) < 12);
    end
    cut = pkt.size();
    r = $urandom_range(0, 99);
    if (kind >= 16 && r < 15) begin
      cut = $urandom_range(1, pkt.size());
    end else if (r < 40) begin
      repeat ($urandom_range(1, 3)) pkt.push_back(pick_byte());
      cut = pkt.size();
    end
    send_buffer(pkt, cut);
  endtask

  always @(negedge clk) begin
    if (stall_left != 0 && !calm) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      stall_left = pause_len();
    end
  end

  always @(posedge clk) begin : take_beat
    out_item_t r;
    bit        hit;
    if (!rst && in_valid && in_ready) begin
      hit = deframe_byte(in_data, r);
      if (pinned_now) begin
        due_results.push_back(pinned_want);
      end else if (hit) begin
        due_results.push_back(r);
      end
    end
  end

  always @(posedge clk) begin : check_result
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        $display("%0t  result with nothing expected: actual %h", $time, out_data);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        check_field("result_kind", want.result_kind, out_data.result_kind);
        check_field("param_byte", want.param_byte, out_data.param_byte);
        check_field("header_offset", want.header_offset, out_data.header_offset);
        check_field("device_id", want.device_id, out_data.device_id);
        check_field("instruction", want.instruction, out_data.instruction);
        check_field("error_byte", want.error_byte, out_data.error_byte);
        check_field("param_count", want.param_count, out_data.param_count);
        check_field("status", want.status, out_data.status);
        if (want.result_kind == RESULT_REPORT) begin
          reports_seen++;
        end
      end
    end
  end

  initial begin : run
    logic [7:0]  pkt [$];
    int unsigned mark;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // header registers stay at reset values except for the mid-packet trigger change
    for (int i = 0; i < $size(PLAN); i++) begin
      if (PLAN[i].cfg_row) begin
        write_reg(PLAN[i].reg_idx, PLAN[i].value);
      end else begin
        send_beat('{data_byte: PLAN[i].value, end_of_buffer: PLAN[i].eob},
                  PLAN[i].pinned, PLAN[i].want);
      end
    end

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: set_headers(8'hFF, 8'hFF, 8'hFD, 8'h00);
        1: set_headers(8'h00, 8'h00, 8'h00, 8'h00);
        2: set_headers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        default: set_headers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      mark = items_sent + 90;
      while (items_sent < mark) random_buffer();
    end

    // a packet cut on a parameter byte, then a max-length packet
    set_headers(8'hFF, 8'hFF, 8'hFD, 8'h00);
    calm = 1'b1;
    append_packet(pkt, 16'd8, 1'b0);
    send_buffer(pkt, 11);
    calm = 1'b0;
    pkt.delete();
    append_packet(pkt, 16'(MAX_LENGTH), 1'b0);
    send_buffer(pkt, pkt.size());

    drain();
    repeat (10) @(negedge clk);
    $display("Sent %0d byte beats (directed, random, cut packet, max-length packet)",
             items_sent);
    $display("under %0d header settings; checked %0d results, %0d of them reports.",
             settings_used + 1, results_seen, reports_seen);
    if (fail_count == 0) begin
      $display("PASS servo_packet_deframer_unit");
    end else begin
      $display("FAIL servo_packet_deframer_unit");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("FAIL servo_packet_deframer_unit");
    $finish;
  end

endmodule

`default_nettype wire
